### sv/cle_pkg.sv
`default_nettype none

package cle_pkg;

   // Field widths of the request and response words.
   localparam int OPCODE_W = 4;
   localparam int POS_W    = 7;
   localparam int COORD_W  = 8;
   localparam int PAIR_W   = 16;
   localparam int FOUND_W  = 7;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 3;

   localparam int DEFAULT_LIST_DEPTH = 128;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_APPEND       = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_POP          = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_GET          = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_SET          = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_INSERT       = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_FIND         = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_VALUE = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_CLEAR        = 4'd8;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

   // Read address select.
   localparam logic [1:0] RD_REQ  = 2'd0;
   localparam logic [1:0] RD_TOP  = 2'd1;
   localparam logic [1:0] RD_SCAN = 2'd2;
   localparam logic [1:0] RD_MID  = 2'd3;

   // Write select for commanded writes.
   localparam logic [1:0] WR_APPEND = 2'd0;
   localparam logic [1:0] WR_SET    = 2'd1;
   localparam logic [1:0] WR_PUT    = 2'd2;

   // Entry count update.
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_CLR  = 2'd3;

   // Scan pointer update.
   localparam logic [2:0] SCAN_HOLD     = 3'd0;
   localparam logic [2:0] SCAN_ZERO     = 3'd1;
   localparam logic [2:0] SCAN_TOP      = 3'd2;
   localparam logic [2:0] SCAN_REQ_NEXT = 3'd3;
   localparam logic [2:0] SCAN_MID_NEXT = 3'd4;
   localparam logic [2:0] SCAN_INC      = 3'd5;
   localparam logic [2:0] SCAN_DEC      = 3'd6;

   // Entry move direction for shifts.
   localparam logic [1:0] MOVE_NONE = 2'd0;
   localparam logic [1:0] MOVE_UP   = 2'd1;
   localparam logic [1:0] MOVE_DOWN = 2'd2;

   // Binary search bound update.
   localparam logic [1:0] BS_HOLD = 2'd0;
   localparam logic [1:0] BS_LO   = 2'd1;
   localparam logic [1:0] BS_HI   = 2'd2;

   // Found index capture.
   localparam logic [1:0] FOUND_HOLD = 2'd0;
   localparam logic [1:0] FOUND_SCAN = 2'd1;
   localparam logic [1:0] FOUND_MID  = 2'd2;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic [1:0]          wr_sel;
      logic [1:0]          cnt_op;
      logic [2:0]          scan_op;
      logic [1:0]          move_op;
      logic [1:0]          bs_op;
      logic                pair_cap;
      logic [1:0]          found_op;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_lt;
      logic pos_le;
      logic pos_eq;
      logic scan_last;
      logic scan_lt_count;
      logic scan_at_pos;
      logic bs_open;
      logic key_eq;
      logic key_gt;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

### sv/coordinate_list_engine.sv
`default_nettype none

// Channel   Direction  Handshake              Word contents
// req_      in         req_valid / req_stall   opcode, position, row_in, col_in
// rsp_      out        rsp_valid / rsp_stall   row_out, col_out, found_at,
//                                              count_out, status
//
// Requests are taken one at a time. Append, set, clear and early failures go
// straight to the response step; get and pop read one entry; insert shifts
// entries up from position, unless at the end; remove_at shifts the rest down;
// find scans from the head; remove_value bisects, then shifts on a hit.
// Synchronous reset empties the list but leaves the pair memory as it is.
// A stalled response holds only the last step of the next request.

module coordinate_list_engine #(
   parameter int LIST_DEPTH = cle_pkg::DEFAULT_LIST_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cle_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [cle_pkg::POS_W-1:0]     req_position,
   input  wire logic [cle_pkg::COORD_W-1:0]   req_row_in,
   input  wire logic [cle_pkg::COORD_W-1:0]   req_col_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cle_pkg::COORD_W-1:0]        rsp_row_out,
   output logic [cle_pkg::COORD_W-1:0]        rsp_col_out,
   output logic [cle_pkg::FOUND_W-1:0]        rsp_found_at,
   output logic [cle_pkg::COUNT_W-1:0]        rsp_count_out,
   output logic [cle_pkg::STATUS_W-1:0]       rsp_status
);

   // The controller sequences each opcode; the datapath holds the pair
   // memory, the entry count, the scan and search pointers and the
   // response register.
   cle_pkg::dp_cmd_type  cmd;
   cle_pkg::dp_stat_type stat;

   cle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   cle_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_position  (req_position),
      .req_row_in    (req_row_in),
      .req_col_in    (req_col_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_out   (rsp_row_out),
      .rsp_col_out   (rsp_col_out),
      .rsp_found_at  (rsp_found_at),
      .rsp_count_out (rsp_count_out),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

### sv/cle_datapath.sv
`default_nettype none

module cle_datapath #(
   parameter int LIST_DEPTH = cle_pkg::DEFAULT_LIST_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cle_pkg::dp_cmd_type             cmd,
   output cle_pkg::dp_stat_type                 stat,
   input  wire logic [cle_pkg::POS_W-1:0]       req_position,
   input  wire logic [cle_pkg::COORD_W-1:0]     req_row_in,
   input  wire logic [cle_pkg::COORD_W-1:0]     req_col_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [cle_pkg::COORD_W-1:0]          rsp_row_out,
   output logic [cle_pkg::COORD_W-1:0]          rsp_col_out,
   output logic [cle_pkg::FOUND_W-1:0]          rsp_found_at,
   output logic [cle_pkg::COUNT_W-1:0]          rsp_count_out,
   output logic [cle_pkg::STATUS_W-1:0]         rsp_status
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > cle_pkg::POS_W) ? CNT_W : cle_pkg::POS_W;

   logic [cle_pkg::PAIR_W-1:0] pair_mem [LIST_DEPTH];

   logic [cle_pkg::PAIR_W-1:0]   rd_data_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         move_ff, move_in;
   logic [IDX_W-1:0]             move_addr_ff, move_addr_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic [CNT_W-1:0]             pos_ff, pos_in;
   logic [cle_pkg::PAIR_W-1:0]   key_ff, key_in;
   logic [cle_pkg::PAIR_W-1:0]   pair_ff, pair_in;
   logic [IDX_W-1:0]             found_ff, found_in;
   logic [CNT_W-1:0]             lo_ff, lo_in;
   logic [CNT_W-1:0]             hi_ff, hi_in;
   logic [IDX_W-1:0]             mid_ff, mid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cle_pkg::PAIR_W-1:0]   rsp_pair_ff, rsp_pair_in;
   logic [cle_pkg::FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [cle_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [cle_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [cle_pkg::PAIR_W-1:0] req_key;
   logic [CNT_W-1:0]           count_dec;
   logic [CNT_W-1:0]           scan_inc;
   logic [CNT_W-1:0]           scan_dec;
   logic [CNT_W-1:0]           bs_span;
   logic [CNT_W-1:0]           mid_wide;
   logic [CMP_W-1:0]           req_pos_cmp;
   logic [CMP_W-1:0]           count_cmp;
   logic [IDX_W-1:0]           rd_addr;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [cle_pkg::PAIR_W-1:0] wr_data;

   assign req_key     = {req_row_in, req_col_in};
   assign count_dec   = count_ff - CNT_W'(1);
   assign scan_inc    = scan_ff + CNT_W'(1);
   assign scan_dec    = scan_ff - CNT_W'(1);
   assign req_pos_cmp = CMP_W'(req_position);
   assign count_cmp   = CMP_W'(count_ff);

   // Midpoint of the open search window, lo + (hi - 1 - lo) / 2 with hi exclusive.
   assign bs_span  = hi_ff - CNT_W'(1) - lo_ff;
   assign mid_wide = lo_ff + (bs_span >> 1);
   assign mid_in   = (cmd.rd_en && cmd.rd_sel == cle_pkg::RD_MID) ? mid_wide[IDX_W-1:0]
                                                                   : mid_ff;

   // Status toward the controller.
   always_comb begin
      stat.full          = (count_ff == CNT_W'(LIST_DEPTH));
      stat.empty         = (count_ff == '0);
      stat.pos_lt        = (req_pos_cmp < count_cmp);
      stat.pos_le        = (req_pos_cmp <= count_cmp);
      stat.pos_eq        = (req_pos_cmp == count_cmp);
      stat.scan_last     = (scan_inc == count_ff);
      stat.scan_lt_count = (scan_ff < count_ff);
      stat.scan_at_pos   = (scan_ff == pos_ff);
      stat.bs_open       = (lo_ff < hi_ff);
      stat.key_eq        = (rd_data_ff == key_ff);
      stat.key_gt        = (rd_data_ff > key_ff);
      stat.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   // Read address.
   always_comb begin
      case (cmd.rd_sel)
         cle_pkg::RD_REQ:  rd_addr = IDX_W'(req_position);
         cle_pkg::RD_TOP:  rd_addr = count_dec[IDX_W-1:0];
         cle_pkg::RD_SCAN: rd_addr = scan_ff[IDX_W-1:0];
         default:          rd_addr = mid_wide[IDX_W-1:0];
      endcase
   end

   // A pending shift move owns the write port; commanded writes never
   // coincide with one.
   always_comb begin
      wr_en   = move_ff || cmd.wr_en;
      wr_addr = move_addr_ff;
      wr_data = rd_data_ff;
      if (!move_ff) begin
         case (cmd.wr_sel)
            cle_pkg::WR_APPEND: begin
               wr_addr = count_ff[IDX_W-1:0];
               wr_data = req_key;
            end
            cle_pkg::WR_SET: begin
               wr_addr = IDX_W'(req_position);
               wr_data = req_key;
            end
            default: begin
               wr_addr = pos_ff[IDX_W-1:0];
               wr_data = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= pair_mem[rd_addr];
      end
   end

   // Next values of the working registers.
   always_comb begin
      case (cmd.cnt_op)
         cle_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
         cle_pkg::CNT_DEC: count_in = count_dec;
         cle_pkg::CNT_CLR: count_in = '0;
         default:          count_in = count_ff;
      endcase

      case (cmd.scan_op)
         cle_pkg::SCAN_ZERO:     scan_in = '0;
         cle_pkg::SCAN_TOP:      scan_in = count_dec;
         cle_pkg::SCAN_REQ_NEXT: scan_in = CNT_W'(req_position) + CNT_W'(1);
         cle_pkg::SCAN_MID_NEXT: scan_in = CNT_W'(mid_ff) + CNT_W'(1);
         cle_pkg::SCAN_INC:      scan_in = scan_inc;
         cle_pkg::SCAN_DEC:      scan_in = scan_dec;
         default:                scan_in = scan_ff;
      endcase

      case (cmd.move_op)
         cle_pkg::MOVE_UP: begin
            move_in      = 1'b1;
            move_addr_in = scan_inc[IDX_W-1:0];
         end
         cle_pkg::MOVE_DOWN: begin
            move_in      = 1'b1;
            move_addr_in = scan_dec[IDX_W-1:0];
         end
         default: begin
            move_in      = 1'b0;
            move_addr_in = move_addr_ff;
         end
      endcase

      pos_in   = pos_ff;
      key_in   = key_ff;
      pair_in  = pair_ff;
      found_in = found_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;

      if (cmd.load) begin
         pos_in   = CNT_W'(req_position);
         key_in   = req_key;
         pair_in  = '0;
         found_in = '0;
         lo_in    = '0;
         hi_in    = count_ff;
      end

      if (cmd.pair_cap) begin
         pair_in = rd_data_ff;
      end

      case (cmd.found_op)
         cle_pkg::FOUND_SCAN: found_in = scan_ff[IDX_W-1:0];
         cle_pkg::FOUND_MID:  found_in = mid_ff;
         default:             ;
      endcase

      case (cmd.bs_op)
         cle_pkg::BS_LO: lo_in = CNT_W'(mid_ff) + CNT_W'(1);
         cle_pkg::BS_HI: hi_in = CNT_W'(mid_ff);
         default:        ;
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pair_in   = rsp_pair_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_pair_in   = pair_ff;
         rsp_found_in  = cle_pkg::FOUND_W'(found_ff);
         rsp_count_in  = cle_pkg::COUNT_W'(count_ff);
         rsp_status_in = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         move_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         move_ff      <= move_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      move_addr_ff  <= move_addr_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      pair_ff       <= pair_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_out   = rsp_pair_ff[cle_pkg::PAIR_W-1:cle_pkg::COORD_W];
   assign rsp_col_out   = rsp_pair_ff[cle_pkg::COORD_W-1:0];
   assign rsp_found_at  = rsp_found_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

### sv/cle_ctrl.sv
`default_nettype none

module cle_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cle_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire cle_pkg::dp_stat_type          stat,
   output cle_pkg::dp_cmd_type                cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CAP      = 4'd1;
   localparam logic [3:0] S_PUT      = 4'd2;
   localparam logic [3:0] S_SHUP     = 4'd3;
   localparam logic [3:0] S_SHDN     = 4'd4;
   localparam logic [3:0] S_FLUSH    = 4'd5;
   localparam logic [3:0] S_RMCAP    = 4'd6;
   localparam logic [3:0] S_FIND_RD  = 4'd7;
   localparam logic [3:0] S_FIND_CMP = 4'd8;
   localparam logic [3:0] S_BS_RD    = 4'd9;
   localparam logic [3:0] S_BS_CMP   = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0]                     state_ff, state_in;
   logic [cle_pkg::OPCODE_W-1:0]   op_ff, op_in;
   logic [cle_pkg::STATUS_W-1:0]   status_ff, status_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;

      cmd            = '0;
      cmd.rd_sel     = cle_pkg::RD_REQ;
      cmd.wr_sel     = cle_pkg::WR_APPEND;
      cmd.cnt_op     = cle_pkg::CNT_HOLD;
      cmd.scan_op    = cle_pkg::SCAN_HOLD;
      cmd.move_op    = cle_pkg::MOVE_NONE;
      cmd.bs_op      = cle_pkg::BS_HOLD;
      cmd.found_op   = cle_pkg::FOUND_HOLD;
      cmd.rsp_status = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               op_in     = req_opcode;
               status_in = cle_pkg::ST_OK;
               state_in  = S_DONE;
               unique case (req_opcode)
                  cle_pkg::OP_APPEND: begin
                     if (stat.full) begin
                        status_in = cle_pkg::ST_FULL;
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = cle_pkg::WR_APPEND;
                        cmd.cnt_op = cle_pkg::CNT_INC;
                     end
                  end
                  cle_pkg::OP_POP: begin
                     if (stat.empty) begin
                        status_in = cle_pkg::ST_EMPTY;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = cle_pkg::RD_TOP;
                        cmd.cnt_op = cle_pkg::CNT_DEC;
                        state_in   = S_CAP;
                     end
                  end
                  cle_pkg::OP_GET: begin
                     if (!stat.pos_lt) begin
                        status_in = cle_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = cle_pkg::RD_REQ;
                        state_in   = S_CAP;
                     end
                  end
                  cle_pkg::OP_SET: begin
                     if (!stat.pos_lt) begin
                        status_in = cle_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = cle_pkg::WR_SET;
                     end
                  end
                  cle_pkg::OP_INSERT: begin
                     if (stat.full) begin
                        status_in = cle_pkg::ST_FULL;
                     end else if (!stat.pos_le) begin
                        status_in = cle_pkg::ST_BAD_INDEX;
                     end else if (stat.pos_eq) begin
                        state_in = S_PUT;
                     end else begin
                        cmd.scan_op = cle_pkg::SCAN_TOP;
                        state_in    = S_SHUP;
                     end
                  end
                  cle_pkg::OP_REMOVE_AT: begin
                     if (stat.empty) begin
                        status_in = cle_pkg::ST_EMPTY;
                     end else if (!stat.pos_lt) begin
                        status_in = cle_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = cle_pkg::RD_REQ;
                        cmd.scan_op = cle_pkg::SCAN_REQ_NEXT;
                        state_in    = S_RMCAP;
                     end
                  end
                  cle_pkg::OP_FIND: begin
                     if (stat.empty) begin
                        status_in = cle_pkg::ST_NOT_FOUND;
                     end else begin
                        cmd.scan_op = cle_pkg::SCAN_ZERO;
                        state_in    = S_FIND_RD;
                     end
                  end
                  cle_pkg::OP_REMOVE_VALUE: begin
                     if (stat.empty) begin
                        status_in = cle_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = S_BS_RD;
                     end
                  end
                  cle_pkg::OP_CLEAR: begin
                     cmd.cnt_op = cle_pkg::CNT_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CAP: begin
            cmd.pair_cap = 1'b1;
            state_in     = S_DONE;
         end
         S_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = cle_pkg::WR_PUT;
            cmd.cnt_op = cle_pkg::CNT_INC;
            state_in   = S_DONE;
         end
         S_SHUP: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = cle_pkg::RD_SCAN;
            cmd.move_op = cle_pkg::MOVE_UP;
            if (stat.scan_at_pos) begin
               state_in = S_FLUSH;
            end else begin
               cmd.scan_op = cle_pkg::SCAN_DEC;
            end
         end
         S_SHDN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = cle_pkg::RD_SCAN;
            cmd.move_op = cle_pkg::MOVE_DOWN;
            if (stat.scan_last) begin
               state_in = S_FLUSH;
            end else begin
               cmd.scan_op = cle_pkg::SCAN_INC;
            end
         end
         S_FLUSH: begin
            if (op_ff == cle_pkg::OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.cnt_op = cle_pkg::CNT_DEC;
               state_in   = S_DONE;
            end
         end
         S_RMCAP: begin
            cmd.pair_cap = 1'b1;
            state_in     = stat.scan_lt_count ? S_SHDN : S_FLUSH;
         end
         S_FIND_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cle_pkg::RD_SCAN;
            state_in   = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (stat.key_eq) begin
               cmd.pair_cap = 1'b1;
               cmd.found_op = cle_pkg::FOUND_SCAN;
               state_in     = S_DONE;
            end else if (stat.scan_last) begin
               status_in = cle_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               cmd.scan_op = cle_pkg::SCAN_INC;
               state_in    = S_FIND_RD;
            end
         end
         S_BS_RD: begin
            if (stat.bs_open) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = cle_pkg::RD_MID;
               state_in   = S_BS_CMP;
            end else begin
               status_in = cle_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_BS_CMP: begin
            if (stat.key_eq) begin
               cmd.found_op = cle_pkg::FOUND_MID;
               cmd.scan_op  = cle_pkg::SCAN_MID_NEXT;
               state_in     = S_RMCAP;
            end else if (stat.key_gt) begin
               cmd.bs_op = cle_pkg::BS_HI;
               state_in  = S_BS_RD;
            end else begin
               cmd.bs_op = cle_pkg::BS_LO;
               state_in  = S_BS_RD;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

### sim/tb_coordinate_list_engine.sv
`timescale 1ns / 1ps

// Self-checking bench for the coordinate list engine.
//
// Each request word is sent through req_valid/req_stall. At the edge where it
// is accepted, a shadow copy of the list (pairs plus entry count) is updated
// the same way the block should update its own. The expected response word is
// queued at that point. A separate process takes every response word accepted
// on rsp_valid/rsp_stall and compares it field by field with the oldest queued
// word.
//
// The stimulus runs in stages, one task each:
//   - error cases on an empty list,
//   - a short hand-written walk through every operation,
//   - filling the list to its depth and working at the full boundary,
//   - many sorted lists built by ordered inserts, then probed and pruned so
//     that the binary-search removal sees real hits,
//   - unconstrained noise, which also leaves the list unsorted.
// The sender idles in bursts. The receiver stalls in phases of its own.
module tb_coordinate_list_engine;

   localparam int LIST_DEPTH = cle_pkg::DEFAULT_LIST_DEPTH;
   localparam int OPCODE_W   = cle_pkg::OPCODE_W;
   localparam int POS_W      = cle_pkg::POS_W;
   localparam int COORD_W    = cle_pkg::COORD_W;
   localparam int PAIR_W     = cle_pkg::PAIR_W;
   localparam int FOUND_W    = cle_pkg::FOUND_W;
   localparam int COUNT_W    = cle_pkg::COUNT_W;
   localparam int STATUS_W   = cle_pkg::STATUS_W;

   // Opcodes the block does not decode; they must leave the list alone.
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LOW  = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HIGH = 4'd15;

   typedef struct packed {
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [FOUND_W-1:0]  found;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // All block inputs start at known values.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [COORD_W-1:0]  req_row_in = '0;
   logic [COORD_W-1:0]  req_col_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COORD_W-1:0]  rsp_row_out;
   logic [COORD_W-1:0]  rsp_col_out;
   logic [FOUND_W-1:0]  rsp_found_at;
   logic [COUNT_W-1:0]  rsp_count_out;
   logic [STATUS_W-1:0] rsp_status;

   // Shadow of the list contents and entry count.
   logic [PAIR_W-1:0] shadow_pairs [LIST_DEPTH];
   int                shadow_count = 0;

   list_result_type pending_results[$];
   bit              mismatch_seen = 1'b0;
   int              burst_left = 0;
   stall_mode_type  stall_mode = STALL_NONE;
   int              stall_phase_left = 0;

   coordinate_list_engine #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_position (req_position),
      .req_row_in   (req_row_in),
      .req_col_in   (req_col_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_row_out  (rsp_row_out),
      .rsp_col_out  (rsp_col_out),
      .rsp_found_at (rsp_found_at),
      .rsp_count_out(rsp_count_out),
      .rsp_status   (rsp_status)
   );

   always #2 clock = ~clock;

   // Closes the gap left by a removed entry and shortens the list by one.
   function automatic void drop_entry(input int idx);
      for (int i = idx; i < shadow_count - 1; i++)
         shadow_pairs[i] = shadow_pairs[i + 1];
      shadow_count--;
   endfunction

   // Applies one request word to the shadow list and returns the response
   // word the block must produce for it. Fields that an operation does not
   // use stay zero, and so do the pair fields of any failed operation.
   function automatic list_result_type apply_list_op(input logic [OPCODE_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [PAIR_W-1:0] key);
      list_result_type   res;
      logic [PAIR_W-1:0] pair;
      int                hit;
      int                lo;
      int                hi;
      int                mid;
      int                p;
      res = '0;
      pair = '0;
      hit = -1;
      p = int'(pos);
      res.status = cle_pkg::ST_OK;
      case (op)
         cle_pkg::OP_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               res.status = cle_pkg::ST_FULL;
            end else begin
               shadow_pairs[shadow_count] = key;
               shadow_count++;
            end
         end
         cle_pkg::OP_POP: begin
            if (shadow_count == 0) begin
               res.status = cle_pkg::ST_EMPTY;
            end else begin
               shadow_count--;
               pair = shadow_pairs[shadow_count];
            end
         end
         cle_pkg::OP_GET: begin
            if (p >= shadow_count) res.status = cle_pkg::ST_BAD_INDEX;
            else pair = shadow_pairs[p];
         end
         cle_pkg::OP_SET: begin
            if (p >= shadow_count) res.status = cle_pkg::ST_BAD_INDEX;
            else shadow_pairs[p] = key;
         end
         cle_pkg::OP_INSERT: begin
            // A full list is reported before the index is looked at.
            if (shadow_count >= LIST_DEPTH) begin
               res.status = cle_pkg::ST_FULL;
            end else if (p > shadow_count) begin
               res.status = cle_pkg::ST_BAD_INDEX;
            end else begin
               for (int i = shadow_count; i > p; i--)
                  shadow_pairs[i] = shadow_pairs[i - 1];
               shadow_pairs[p] = key;
               shadow_count++;
            end
         end
         cle_pkg::OP_REMOVE_AT: begin
            if (shadow_count == 0) begin
               res.status = cle_pkg::ST_EMPTY;
            end else if (p >= shadow_count) begin
               res.status = cle_pkg::ST_BAD_INDEX;
            end else begin
               pair = shadow_pairs[p];
               drop_entry(p);
            end
         end
         cle_pkg::OP_FIND: begin
            // The first match from the head of the list wins.
            for (int i = 0; i < shadow_count; i++)
               if (hit < 0 && shadow_pairs[i] == key) hit = i;
            if (hit < 0) begin
               res.status = cle_pkg::ST_NOT_FOUND;
            end else begin
               res.found = FOUND_W'(hit);
               pair = shadow_pairs[hit];
            end
         end
         cle_pkg::OP_REMOVE_VALUE: begin
            // Binary search in row-then-column order. On an unsorted list it
            // can miss a pair that is present, and that miss is expected.
            lo = 0;
            hi = shadow_count - 1;
            while (hi >= lo && hit < 0) begin
               mid = lo + (hi - lo) / 2;
               if (shadow_pairs[mid] == key) hit = mid;
               else if (shadow_pairs[mid] > key) hi = mid - 1;
               else lo = mid + 1;
            end
            if (hit < 0) begin
               res.status = cle_pkg::ST_NOT_FOUND;
            end else begin
               res.found = FOUND_W'(hit);
               pair = shadow_pairs[hit];
               drop_entry(hit);
            end
         end
         cle_pkg::OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      res.row = pair[PAIR_W-1:COORD_W];
      res.col = pair[COORD_W-1:0];
      res.count = COUNT_W'(shadow_count);
      return res;
   endfunction

   // Index at which a pair must go to keep the list in ascending order.
   function automatic int sorted_slot(input logic [PAIR_W-1:0] key);
      int slot;
      slot = 0;
      while (slot < shadow_count && shadow_pairs[slot] < key) slot++;
      return slot;
   endfunction

   // A pair that is in the list now. The caller makes sure it is not empty.
   function automatic logic [PAIR_W-1:0] stored_pair();
      return shadow_pairs[$urandom_range(0, shadow_count - 1)];
   endfunction

   // A narrow key space uses only four values per coordinate, which makes
   // duplicate pairs and search hits common.
   function automatic logic [PAIR_W-1:0] random_pair(input bit narrow);
      if (narrow)
         return {8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 3) * 85)};
      return 16'($urandom);
   endfunction

   function automatic logic [POS_W-1:0] position_near_count();
      int pos_limit;
      pos_limit = (shadow_count > 127) ? 127 : shadow_count;
      return 7'($urandom_range(0, pos_limit));
   endfunction

   // Sends one request word and returns once it is accepted and any idle gap
   // after it is over. The word holds still while the block stalls. Valid is
   // dropped only when a real gap follows, so back-to-back words never lower
   // and raise it in the same step.
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [PAIR_W-1:0] key);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_row_in <= key[PAIR_W-1:COORD_W];
      req_col_in <= key[COORD_W-1:0];
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_results.push_back(apply_list_op(op, pos, key));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Every failing operation on an empty list, plus the undecoded opcodes and a clear.
   task automatic test_empty_list();
      send_word(cle_pkg::OP_POP, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_REMOVE_AT, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_GET, 7'd0, 16'hFFFF);
      send_word(cle_pkg::OP_SET, 7'd127, 16'hFFFF);
      send_word(cle_pkg::OP_FIND, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_REMOVE_VALUE, 7'd0, 16'hFFFF);
      send_word(cle_pkg::OP_INSERT, 7'd1, 16'h1234);
      send_word(OP_UNUSED_LOW, 7'd5, 16'h5A5A);
      send_word(OP_UNUSED_HIGH, 7'd127, 16'hFFFF);
      send_word(cle_pkg::OP_CLEAR, 7'd127, 16'hFFFF);
   endtask

   // A short walk through every operation on a small sorted list. The pairs
   // sit at the coordinate extremes.
   task automatic test_basic_ops();
      send_word(cle_pkg::OP_INSERT, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_APPEND, 7'd0, 16'hFFFF);
      send_word(cle_pkg::OP_INSERT, 7'd1, 16'h8001);
      send_word(cle_pkg::OP_INSERT, 7'd2, 16'h80FE);
      send_word(cle_pkg::OP_GET, 7'd3, 16'h0000);
      send_word(cle_pkg::OP_GET, 7'd4, 16'h0000);
      send_word(cle_pkg::OP_SET, 7'd0, 16'h0001);
      send_word(cle_pkg::OP_FIND, 7'd0, 16'h80FE);
      send_word(cle_pkg::OP_FIND, 7'd0, 16'h7F7F);
      send_word(cle_pkg::OP_REMOVE_VALUE, 7'd0, 16'h8001);
      send_word(cle_pkg::OP_REMOVE_VALUE, 7'd0, 16'h7FFF);
      send_word(cle_pkg::OP_REMOVE_AT, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_REMOVE_AT, 7'd5, 16'h0000);
      send_word(cle_pkg::OP_POP, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_INSERT, 7'd2, 16'hAAAA);
      send_word(cle_pkg::OP_CLEAR, 7'd0, 16'h0000);
   endtask

   // Fills the list with random pairs, then works at the full boundary and
   // at both ends. The content is unsorted here, so the value removals may
   // legitimately miss pairs that are present.
   task automatic test_full_list();
      send_word(cle_pkg::OP_CLEAR, 7'd0, 16'h0000);
      repeat (LIST_DEPTH) send_word(cle_pkg::OP_APPEND, 7'($urandom), 16'($urandom));
      send_word(cle_pkg::OP_APPEND, 7'd0, 16'($urandom));
      send_word(cle_pkg::OP_INSERT, 7'd0, 16'($urandom));
      send_word(cle_pkg::OP_INSERT, 7'd127, 16'($urandom));
      send_word(cle_pkg::OP_GET, 7'd127, 16'h0000);
      send_word(cle_pkg::OP_SET, 7'd127, 16'hFFFF);
      send_word(cle_pkg::OP_FIND, 7'd0, 16'hFFFF);
      send_word(cle_pkg::OP_REMOVE_AT, 7'd127, 16'h0000);
      send_word(cle_pkg::OP_INSERT, 7'd127, 16'h00FF);
      send_word(cle_pkg::OP_REMOVE_AT, 7'd0, 16'h0000);
      send_word(cle_pkg::OP_INSERT, 7'd0, 16'hFF00);
      send_word(cle_pkg::OP_POP, 7'd0, 16'h0000);
      repeat (4) send_word(cle_pkg::OP_REMOVE_VALUE, 7'($urandom), stored_pair());
      repeat (2) send_word(cle_pkg::OP_FIND, 7'($urandom), 16'($urandom));
      send_word(cle_pkg::OP_CLEAR, 7'($urandom), 16'($urandom));
   endtask

   // The bulk of the run. Each list starts from a clear and is grown by
   // inserts at the ordered position toward a target size. Only operations
   // that keep the order are used on it, so the value removal sees a sorted
   // list and finds what it is asked for. Most targets are small. A few go
   // up to the full depth.
   task automatic test_sorted_lists(input int n_lists);
      int                target;
      int                pick;
      int                p;
      bit                narrow;
      logic [PAIR_W-1:0] key;
      logic [PAIR_W-1:0] lo_key;
      logic [PAIR_W-1:0] hi_key;
      repeat (n_lists) begin
         target = ($urandom_range(0, 7) == 0) ? $urandom_range(60, LIST_DEPTH)
                                              : $urandom_range(1, 20);
         narrow = ($urandom_range(0, 2) == 0);
         send_word(cle_pkg::OP_CLEAR, 7'($urandom), 16'($urandom));
         repeat (target + $urandom_range(5, 30)) begin
            pick = $urandom_range(0, 99);
            key = random_pair(narrow);
            // Once the list has reached its target, the share of inserts
            // falls through to removals, which holds the size near it.
            if (pick < 45 && shadow_count < target) begin
               send_word(cle_pkg::OP_INSERT, 7'(sorted_slot(key)), key);
            end else if (pick < 60) begin
               if (shadow_count > 0 && $urandom_range(0, 3) != 0) key = stored_pair();
               send_word(cle_pkg::OP_REMOVE_VALUE, 7'($urandom), key);
            end else if (pick < 72) begin
               if (shadow_count > 0 && $urandom_range(0, 3) != 0) key = stored_pair();
               send_word(cle_pkg::OP_FIND, 7'($urandom), key);
            end else if (pick < 80) begin
               send_word(cle_pkg::OP_GET, position_near_count(), key);
            end else if (pick < 86) begin
               if (shadow_count > 0) begin
                  // A new value between the neighbors keeps the order.
                  p = $urandom_range(0, shadow_count - 1);
                  lo_key = (p > 0) ? shadow_pairs[p - 1] : 16'h0000;
                  hi_key = (p < shadow_count - 1) ? shadow_pairs[p + 1] : 16'hFFFF;
                  key = 16'($urandom_range(hi_key, lo_key));
                  send_word(cle_pkg::OP_SET, 7'(p), key);
               end else begin
                  send_word(cle_pkg::OP_SET, position_near_count(), key);
               end
            end else if (pick < 92) begin
               send_word(cle_pkg::OP_REMOVE_AT, position_near_count(), key);
            end else if (pick < 96) begin
               send_word(cle_pkg::OP_POP, 7'($urandom), key);
            end else begin
               if (shadow_count > 0)
                  key = 16'($urandom_range(16'hFFFF, shadow_pairs[shadow_count - 1]));
               send_word(cle_pkg::OP_APPEND, 7'($urandom), key);
            end
         end
      end
   endtask

   // Unconstrained words: any opcode including the undecoded ones, any
   // position, and any pair. Half the positions land near the count and half
   // the pairs are ones already stored, so hits and boundaries keep showing up.
   task automatic test_random_noise(input int n_items);
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      logic [PAIR_W-1:0]   key;
      repeat (n_items) begin
         op = ($urandom_range(0, 3) == 0) ? OPCODE_W'($urandom)
                                          : OPCODE_W'($urandom_range(0, 8));
         pos = ($urandom_range(0, 1) == 0) ? position_near_count() : 7'($urandom);
         key = (shadow_count > 0 && $urandom_range(0, 1) == 0) ? stored_pair()
                                                               : 16'($urandom);
         send_word(op, pos, key);
      end
   endtask

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // Response checker. A word counts as delivered at an edge where valid is
   // high and our stall is low. Both are read as they stood before the edge.
   always @(posedge clock) begin : response_check
      list_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("response word arrived with no request outstanding");
            mismatch_seen = 1'b1;
         end else begin
            want = pending_results.pop_front();
            check_field("row_out", want.row, rsp_row_out);
            check_field("col_out", want.col, rsp_col_out);
            check_field("found_at", want.found, rsp_found_at);
            check_field("count_out", want.count, rsp_count_out);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   // The receiver changes its stall behavior from one phase to the next. It
   // can take every word, stall lightly or heavily at random, or stall in a
   // fixed rhythm that lines up with different phases of the block's work.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(20, 200);
      end else begin
         stall_phase_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ((stall_phase_left % 16) < 6);
      endcase
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_sorted_lists(24);
      test_random_noise(300);
      req_valid <= 1'b0;
      // Drain the outstanding responses. Then keep the clock running so that any
      // stray extra word would still be seen by the checker.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (!mismatch_seen) begin
         $display("coordinate_list_engine: match");
      end else begin
         $display("coordinate_list_engine: mismatch");
      end
      $finish;
   end

   // Watchdog, set far beyond the slowest legal run: every word a full-list
   // search or shift, with worst-case idling on both sides.
   initial begin
      #20_000_000;
      $display("coordinate_list_engine: mismatch");
      $finish;
   end

endmodule
